// ===== rtl/eth_ipv4_l4_header_parser_top_macros.svh =====
// Assertion helpers shared by the parser modules. Each expects clk and arst_n in scope.
`ifndef ETH_IPV4_L4_HEADER_PARSER_TOP_MACROS_SVH
`define ETH_IPV4_L4_HEADER_PARSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIPP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EIPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/eipp_pkg.sv =====
`timescale 1ns / 1ps

package eipp_pkg;

	// Width of the frame byte counter; it saturates at its all-ones value.
	localparam int unsigned CNT_W = 16;

	localparam int unsigned ETH_LEN     = 14;
	localparam int unsigned UDP_HDR     = 8;
	localparam int unsigned DNS_HDR     = 12;
	localparam int unsigned MIN_HDR     = 20;
	localparam int unsigned PROTO_TCP   = 6;
	localparam int unsigned PROTO_UDP   = 17;
	localparam int unsigned DNS_PORT_RST = 53;

	// Depth of the queue between front and back.
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_TCP       = 4'd0,
		ST_UDP       = 4'd1,
		ST_DNS_QUERY = 4'd2,
		ST_DNS_RESP  = 4'd3,
		ST_OTHER     = 4'd4,
		ST_BAD_IP    = 4'd5,
		ST_BAD_TCP   = 4'd6,
		ST_DNS_SHORT = 4'd7,
		ST_TRUNC     = 4'd8
	} status_t;

	// Everything latched for one frame, handed from front to back.
	typedef struct packed {
		logic [15:0]      frame_type;
		logic [3:0]       version;
		logic [5:0]       hdr_bytes;
		logic [7:0]       ttl;
		logic [7:0]       protocol;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [15:0]      sport;
		logic [15:0]      dport;
		logic [15:0]      udp_len;
		logic [5:0]       flags;
		logic [5:0]       tcp_hdr_bytes;
		logic             dns_qr;
		logic [CNT_W-1:0] cap_len;
	} frame_rec_t;

endpackage

// ===== rtl/eipp_front.sv =====
`timescale 1ns / 1ps
`include "eth_ipv4_l4_header_parser_top_macros.svh"

module eipp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 q_full,
	output logic                 q_push,
	output eipp_pkg::frame_rec_t q_rec
);

	localparam logic [eipp_pkg::CNT_W-1:0] CNT_MAX = {eipp_pkg::CNT_W{1'b1}};

	logic [eipp_pkg::CNT_W-1:0] offset_q;
	logic [15:0] type_q, sport_q, dport_q, udp_len_q;
	logic [3:0]  version_q;
	logic [5:0]  hdr_bytes_q, tcp_hdr_q, flags_q;
	logic [7:0]  ttl_q, proto_q;
	logic [31:0] src_q, dst_q;
	logic        dns_qr_q;

	logic [15:0] type_d, sport_d, dport_d, udp_len_d;
	logic [3:0]  version_d;
	logic [5:0]  hdr_bytes_d, tcp_hdr_d, flags_d;
	logic [7:0]  ttl_d, proto_d;
	logic [31:0] src_d, dst_d;
	logic        dns_qr_d;

	logic [eipp_pkg::CNT_W-1:0] l4_start, l4_rel, offset_inc;
	logic                       in_l4;
	logic [3:0]                 rel;
	logic                       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && last_byte;

	assign offset_inc = (offset_q == CNT_MAX) ? offset_q : offset_q + 1'b1;

	// The transport header begins right after the IP header, once its length is sane.
	assign l4_start = eipp_pkg::CNT_W'(eipp_pkg::ETH_LEN) + eipp_pkg::CNT_W'(hdr_bytes_q);
	assign l4_rel   = offset_q - l4_start;
	assign in_l4    = (offset_q >= eipp_pkg::CNT_W'(eipp_pkg::ETH_LEN + 1))
		&& (hdr_bytes_q >= 6'(eipp_pkg::MIN_HDR))
		&& (offset_q >= l4_start) && (l4_rel < eipp_pkg::CNT_W'(14));
	assign rel = l4_rel[3:0];

	always_comb begin
		type_d      = type_q;
		version_d   = version_q;
		hdr_bytes_d = hdr_bytes_q;
		ttl_d       = ttl_q;
		proto_d     = proto_q;
		src_d       = src_q;
		dst_d       = dst_q;
		sport_d     = sport_q;
		dport_d     = dport_q;
		udp_len_d   = udp_len_q;
		tcp_hdr_d   = tcp_hdr_q;
		flags_d     = flags_q;
		dns_qr_d    = dns_qr_q;
		if (offset_q == eipp_pkg::CNT_W'(12)) begin
			type_d[15:8] = data_byte;
		end else if (offset_q == eipp_pkg::CNT_W'(13)) begin
			type_d[7:0] = data_byte;
		end else if (offset_q == eipp_pkg::CNT_W'(14)) begin
			version_d   = data_byte[7:4];
			hdr_bytes_d = {data_byte[3:0], 2'b00};
		end else if (offset_q == eipp_pkg::CNT_W'(22)) begin
			ttl_d = data_byte;
		end else if (offset_q == eipp_pkg::CNT_W'(23)) begin
			proto_d = data_byte;
		end else if (offset_q >= eipp_pkg::CNT_W'(26) && offset_q <= eipp_pkg::CNT_W'(29)) begin
			src_d = {src_q[23:0], data_byte};
		end else if (offset_q >= eipp_pkg::CNT_W'(30) && offset_q <= eipp_pkg::CNT_W'(33)) begin
			dst_d = {dst_q[23:0], data_byte};
		end
		if (in_l4) begin
			case (rel)
				4'd0:    sport_d[15:8]   = data_byte;
				4'd1:    sport_d[7:0]    = data_byte;
				4'd2:    dport_d[15:8]   = data_byte;
				4'd3:    dport_d[7:0]    = data_byte;
				4'd4:    udp_len_d[15:8] = data_byte;
				4'd5:    udp_len_d[7:0]  = data_byte;
				4'd10:   dns_qr_d        = data_byte[7];
				4'd12:   tcp_hdr_d       = {data_byte[7:4], 2'b00};
				4'd13:   flags_d         = data_byte[5:0];
				default: ;
			endcase
		end
	end

	// The request leaves with the fields as updated by its own last byte.
	always_comb begin
		q_rec.frame_type    = type_d;
		q_rec.version       = version_d;
		q_rec.hdr_bytes     = hdr_bytes_d;
		q_rec.ttl           = ttl_d;
		q_rec.protocol      = proto_d;
		q_rec.src_addr      = src_d;
		q_rec.dst_addr      = dst_d;
		q_rec.sport         = sport_d;
		q_rec.dport         = dport_d;
		q_rec.udp_len       = udp_len_d;
		q_rec.flags         = flags_d;
		q_rec.tcp_hdr_bytes = tcp_hdr_d;
		q_rec.dns_qr        = dns_qr_d;
		q_rec.cap_len       = offset_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			type_q      <= '0;
			version_q   <= '0;
			hdr_bytes_q <= '0;
			ttl_q       <= '0;
			proto_q     <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			sport_q     <= '0;
			dport_q     <= '0;
			udp_len_q   <= '0;
			tcp_hdr_q   <= '0;
			flags_q     <= '0;
			dns_qr_q    <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				offset_q    <= '0;
				type_q      <= '0;
				version_q   <= '0;
				hdr_bytes_q <= '0;
				ttl_q       <= '0;
				proto_q     <= '0;
				src_q       <= '0;
				dst_q       <= '0;
				sport_q     <= '0;
				dport_q     <= '0;
				udp_len_q   <= '0;
				tcp_hdr_q   <= '0;
				flags_q     <= '0;
				dns_qr_q    <= 1'b0;
			end else begin
				offset_q    <= offset_inc;
				type_q      <= type_d;
				version_q   <= version_d;
				hdr_bytes_q <= hdr_bytes_d;
				ttl_q       <= ttl_d;
				proto_q     <= proto_d;
				src_q       <= src_d;
				dst_q       <= dst_d;
				sport_q     <= sport_d;
				dport_q     <= dport_d;
				udp_len_q   <= udp_len_d;
				tcp_hdr_q   <= tcp_hdr_d;
				flags_q     <= flags_d;
				dns_qr_q    <= dns_qr_d;
			end
		end
	end

	`EIPP_ASSERT_NEXT(a_frame_restart, q_push, (offset_q == '0) && (hdr_bytes_q == '0), "frame state not cleared after last byte")

endmodule

// ===== rtl/eipp_queue.sv =====
`timescale 1ns / 1ps
`include "eth_ipv4_l4_header_parser_top_macros.svh"

module eipp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  eipp_pkg::frame_rec_t push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output eipp_pkg::frame_rec_t head_rec
);

	eipp_pkg::frame_rec_t mem_q [eipp_pkg::Q_DEPTH];

	logic [eipp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [eipp_pkg::QCNT_W-1:0] count_q;

	localparam logic [eipp_pkg::QPTR_W-1:0] PTR_LAST = eipp_pkg::QPTR_W'(eipp_pkg::Q_DEPTH - 1);
	localparam logic [eipp_pkg::QCNT_W-1:0] CNT_FULL = eipp_pkg::QCNT_W'(eipp_pkg::Q_DEPTH);

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`EIPP_ASSERT_SAME(a_no_overflow, push, !full, "request pushed into a full queue")
	`EIPP_ASSERT_SAME(a_no_underflow, pop, !empty, "request popped from an empty queue")

endmodule

// ===== rtl/eipp_back.sv =====
`timescale 1ns / 1ps
`include "eth_ipv4_l4_header_parser_top_macros.svh"

module eipp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          dns_port_val,
	input  logic                 q_empty,
	input  eipp_pkg::frame_rec_t head_rec,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          frame_type,
	output logic [3:0]           ip_version,
	output logic [5:0]           ip_header_bytes,
	output logic [7:0]           hop_limit,
	output logic [7:0]           ip_protocol,
	output logic [31:0]          source_address,
	output logic [31:0]          dest_address,
	output logic [15:0]          source_port,
	output logic [15:0]          dest_port,
	output logic [5:0]           tcp_flag_bits,
	output logic [15:0]          payload_bytes,
	output logic [3:0]           status
);

	logic        out_valid_q;
	logic [15:0] type_q, sport_q, dport_q, pay_q;
	logic [3:0]  version_q;
	logic [5:0]  hdr_q, flags_q;
	logic [7:0]  ttl_q, proto_q;
	logic [31:0] src_q, dst_q;
	eipp_pkg::status_t st_q;

	logic [15:0] cap, ip_end, tcp_end, sport_c, dport_c, pay_c;
	logic [5:0]  flags_c;
	logic        bad_ip;
	eipp_pkg::status_t st_c;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	assign cap     = 16'(head_rec.cap_len);
	assign ip_end  = 16'(eipp_pkg::ETH_LEN) + 16'(head_rec.hdr_bytes);
	assign tcp_end = ip_end + 16'(head_rec.tcp_hdr_bytes);

	always_comb begin
		sport_c = '0;
		dport_c = '0;
		flags_c = '0;
		pay_c   = '0;
		bad_ip  = 1'b0;
		st_c    = eipp_pkg::ST_OTHER;
		if (cap < 16'(eipp_pkg::ETH_LEN + 1)) begin
			st_c = eipp_pkg::ST_TRUNC;
		end else if (head_rec.hdr_bytes < 6'(eipp_pkg::MIN_HDR)) begin
			st_c   = eipp_pkg::ST_BAD_IP;
			bad_ip = 1'b1;
		end else if (cap < ip_end) begin
			st_c = eipp_pkg::ST_TRUNC;
		end else if (head_rec.protocol == 8'(eipp_pkg::PROTO_TCP)) begin
			if (cap < ip_end + 16'(eipp_pkg::MIN_HDR)) begin
				st_c = eipp_pkg::ST_TRUNC;
			end else begin
				sport_c = head_rec.sport;
				dport_c = head_rec.dport;
				flags_c = head_rec.flags;
				pay_c   = (cap > tcp_end) ? cap - tcp_end : '0;
				st_c    = (head_rec.tcp_hdr_bytes < 6'(eipp_pkg::MIN_HDR))
					? eipp_pkg::ST_BAD_TCP : eipp_pkg::ST_TCP;
			end
		end else if (head_rec.protocol == 8'(eipp_pkg::PROTO_UDP)) begin
			if (cap < ip_end + 16'(eipp_pkg::UDP_HDR)) begin
				st_c = eipp_pkg::ST_TRUNC;
			end else begin
				sport_c = head_rec.sport;
				dport_c = head_rec.dport;
				pay_c   = (head_rec.udp_len > 16'(eipp_pkg::UDP_HDR))
					? head_rec.udp_len - 16'(eipp_pkg::UDP_HDR) : '0;
				if (head_rec.sport == dns_port_val || head_rec.dport == dns_port_val) begin
					if (cap < ip_end + 16'(eipp_pkg::UDP_HDR + eipp_pkg::DNS_HDR)) begin
						st_c = eipp_pkg::ST_DNS_SHORT;
					end else begin
						st_c = head_rec.dns_qr ? eipp_pkg::ST_DNS_RESP : eipp_pkg::ST_DNS_QUERY;
					end
				end else begin
					st_c = eipp_pkg::ST_UDP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			type_q    <= head_rec.frame_type;
			version_q <= head_rec.version;
			hdr_q     <= head_rec.hdr_bytes;
			ttl_q     <= bad_ip ? '0 : head_rec.ttl;
			proto_q   <= bad_ip ? '0 : head_rec.protocol;
			src_q     <= bad_ip ? '0 : head_rec.src_addr;
			dst_q     <= bad_ip ? '0 : head_rec.dst_addr;
			sport_q   <= sport_c;
			dport_q   <= dport_c;
			flags_q   <= flags_c;
			pay_q     <= pay_c;
			st_q      <= st_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_type      = type_q;
	assign ip_version      = version_q;
	assign ip_header_bytes = hdr_q;
	assign hop_limit       = ttl_q;
	assign ip_protocol     = proto_q;
	assign source_address  = src_q;
	assign dest_address    = dst_q;
	assign source_port     = sport_q;
	assign dest_port       = dport_q;
	assign tcp_flag_bits   = flags_q;
	assign payload_bytes   = pay_q;
	assign status          = st_q;

	`EIPP_ASSERT_SAME(a_bad_ip_clean, out_valid_q && (st_q == eipp_pkg::ST_BAD_IP), (src_q == '0) && (sport_q == '0) && (pay_q == '0), "bad IP result carries addresses or ports")
	`EIPP_ASSERT_SAME(a_udp_no_flags, out_valid_q && (st_q != eipp_pkg::ST_TCP) && (st_q != eipp_pkg::ST_BAD_TCP), flags_q == '0, "TCP flags reported on a non-TCP result")

endmodule

// ===== rtl/eth_ipv4_l4_header_parser_top.sv =====
`timescale 1ns / 1ps
// Ethernet / IPv4 / TCP / UDP header parser.
// Input channel: one captured frame byte per request on data_byte, starting at the
// destination MAC, with last_byte set on the final byte. A request is taken on a clock
// edge with in_valid high and in_stall low. One byte is taken per cycle while not stalled.
// Output channel: one summary per frame (addresses, ports, flags, payload length and
// status), taken on an edge with out_valid high and out_stall low.
// After the last byte is taken, the frame's fields are written into a two-entry frame
// queue and then into the back's classification register, which raises out_valid.
// Throughput: one byte per cycle while in_stall is low; a frame of any length, down to one
// byte, can follow the previous one in the next cycle.
// When the receiver stalls the output holds and the queue fills; in_stall rises only
// once two finished frames wait behind the held summary. Until then bytes are taken as
// usual; while in_stall is high no byte at all is taken.
// Reset clears the byte counter, latched fields, queue and output valid; dns_port goes to 53.
// The user must write dns_port (dns_port_wen) only while the block is idle; not enforced.

module eth_ipv4_l4_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dns_port_wen,
	input  logic [15:0] dns_port_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] frame_type,
	output logic [3:0]  ip_version,
	output logic [5:0]  ip_header_bytes,
	output logic [7:0]  hop_limit,
	output logic [7:0]  ip_protocol,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [5:0]  tcp_flag_bits,
	output logic [15:0] payload_bytes,
	output logic [3:0]  status
);

	logic [15:0]          dns_port_q;
	logic                 q_full, q_empty, q_push, q_pop;
	eipp_pkg::frame_rec_t push_rec, head_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= 16'(eipp_pkg::DNS_PORT_RST);
		end else if (dns_port_wen) begin
			dns_port_q <= dns_port_wdata;
		end
	end

	eipp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_rec     (push_rec)
	);

	eipp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_rec (head_rec)
	);

	eipp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.dns_port_val    (dns_port_q),
		.q_empty         (q_empty),
		.head_rec        (head_rec),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_type      (frame_type),
		.ip_version      (ip_version),
		.ip_header_bytes (ip_header_bytes),
		.hop_limit       (hop_limit),
		.ip_protocol     (ip_protocol),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.source_port     (source_port),
		.dest_port       (dest_port),
		.tcp_flag_bits   (tcp_flag_bits),
		.payload_bytes   (payload_bytes),
		.status          (status)
	);

endmodule
